// File: sv/gsa_pkg.sv
package gsa_pkg;

    // Table geometry.
    localparam int SLOTS  = 1024;
    localparam int IDX_W  = 10;
    localparam int GROUPS = 8;
    localparam int REV_W  = 16;
    localparam int CNT_W  = 11;
    localparam int WORD_W = 32;
    localparam int WSEL_W = 5;
    localparam int BSEL_W = 5;
    localparam int WORDS  = SLOTS / WORD_W;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 48;

    typedef enum logic [1:0] {
        CMD_SPAWN = 2'd0,
        CMD_KILL  = 2'd1,
        CMD_PASS  = 2'd2,
        CMD_JOIN  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_NULL   = 3'd2,
        ST_STALE  = 3'd3,
        ST_MEMBER = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SP_A,
        S_SP_B,
        S_RD,
        S_PS_RD,
        S_PS_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [REV_W-1:0]  rev;
        logic              in_use;
        logic              mark;
        logic [GROUPS-1:0] groups;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic req_ld;
        logic sp_rd_word;
        logic sp_rd_entry;
        logic rd_entry;
        logic ps_rd;
        logic ps_wr;
        logic fin;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic full;
        logic ps_last;
        logic out_free;
    } t_sts;

    // Position of the lowest clear bit of a word.
    function automatic logic [BSEL_W-1:0] first_zero(input logic [WORD_W-1:0] v);
        logic [BSEL_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = BSEL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: sv/gsa_ctrl.sv
module gsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  gsa_pkg::t_cmd i_cmd,
    input  gsa_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output gsa_pkg::t_ctl o_ctl
);

    gsa_pkg::t_state r_state;
    gsa_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            gsa_pkg::S_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            gsa_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctl.req_ld = 1'b1;
                    case (i_cmd)
                        gsa_pkg::CMD_SPAWN: n_state = gsa_pkg::S_SP_A;
                        gsa_pkg::CMD_PASS:  n_state = gsa_pkg::S_PS_RD;
                        default:            n_state = gsa_pkg::S_RD;
                    endcase
                end
            end
            gsa_pkg::S_SP_A: begin
                if (i_sts.full) begin
                    n_state = gsa_pkg::S_FIN;
                end else begin
                    o_ctl.sp_rd_word = 1'b1;
                    n_state = gsa_pkg::S_SP_B;
                end
            end
            gsa_pkg::S_SP_B: begin
                o_ctl.sp_rd_entry = 1'b1;
                n_state = gsa_pkg::S_FIN;
            end
            gsa_pkg::S_RD: begin
                o_ctl.rd_entry = 1'b1;
                n_state = gsa_pkg::S_FIN;
            end
            gsa_pkg::S_PS_RD: begin
                o_ctl.ps_rd = 1'b1;
                n_state = gsa_pkg::S_PS_WR;
            end
            gsa_pkg::S_PS_WR: begin
                o_ctl.ps_wr = 1'b1;
                n_state = i_sts.ps_last ? gsa_pkg::S_FIN : gsa_pkg::S_PS_RD;
            end
            gsa_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.fin = 1'b1;
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gsa_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != gsa_pkg::S_IDLE))
        else $error("request accepted but controller stayed idle");
    a_fin_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.fin |-> i_sts.out_free)
        else $error("result issued while output register busy");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.clr_wr, o_ctl.ps_wr, o_ctl.fin}))
        else $error("more than one table write command");
`endif

endmodule

// File: sv/gsa_dpath.sv
module gsa_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gsa_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                        i_m_tready,
    input  gsa_pkg::t_ctl               i_ctl,
    output gsa_pkg::t_sts               o_sts,
    output logic                        o_m_tvalid,
    output logic [gsa_pkg::OUT_W-1:0]   o_m_tdata
);

    // Slot table and alive bitmap (32 slots per word).
    gsa_pkg::t_entry             entry_mem [gsa_pkg::SLOTS];
    logic [gsa_pkg::WORD_W-1:0]  alive_mem [gsa_pkg::WORDS];

    // Latched request.
    gsa_pkg::t_cmd               r_cmd;
    logic [gsa_pkg::IDX_W-1:0]   r_idx;
    logic                        r_hv;
    logic [gsa_pkg::REV_W-1:0]   r_hrev;
    logic [2:0]                  r_grp;

    logic [gsa_pkg::IDX_W-1:0]   r_cnt;
    logic [gsa_pkg::WSEL_W-1:0]  r_wsel;
    logic [gsa_pkg::IDX_W-1:0]   r_slot;
    logic [gsa_pkg::WORDS-1:0]   r_sum;
    logic [gsa_pkg::CNT_W-1:0]   r_mark_count;
    gsa_pkg::t_entry             r_entry_q;
    logic [gsa_pkg::WORD_W-1:0]  r_alive_q;
    logic                        r_out_valid;
    logic [gsa_pkg::OUT_W-1:0]   r_out_data;

    logic [gsa_pkg::WSEL_W-1:0]  w_wlow;
    logic [gsa_pkg::BSEL_W-1:0]  w_blow;
    logic [gsa_pkg::WORD_W-1:0]  w_spawn_bit;
    logic [gsa_pkg::WORD_W-1:0]  w_pass_bit;
    logic                        w_full;
    logic                        w_marks_full;
    gsa_pkg::t_status            w_chk;
    logic [gsa_pkg::GROUPS-1:0]  w_gbit;

    logic                        w_ent_we;
    logic [gsa_pkg::IDX_W-1:0]   w_ent_wa;
    gsa_pkg::t_entry             w_ent_wd;
    logic                        w_ent_re;
    logic [gsa_pkg::IDX_W-1:0]   w_ent_ra;
    logic                        w_alv_we;
    logic [gsa_pkg::WSEL_W-1:0]  w_alv_wa;
    logic [gsa_pkg::WORD_W-1:0]  w_alv_wd;
    logic                        w_alv_re;
    logic [gsa_pkg::WSEL_W-1:0]  w_alv_ra;

    gsa_pkg::t_status            w_status;
    logic [gsa_pkg::IDX_W-1:0]   w_oidx;
    logic                        w_ovalid;
    logic [gsa_pkg::REV_W-1:0]   w_orev;
    logic [gsa_pkg::CNT_W-1:0]   w_removed;
    logic                        w_mark_inc;

    // Free-slot search and handle check.
    always_comb begin
        w_wlow       = gsa_pkg::first_zero(r_sum);
        w_blow       = gsa_pkg::first_zero(r_alive_q);
        w_spawn_bit  = gsa_pkg::WORD_W'(1) << r_slot[gsa_pkg::BSEL_W-1:0];
        w_pass_bit   = gsa_pkg::WORD_W'(1) << r_cnt[gsa_pkg::BSEL_W-1:0];
        w_full       = &r_sum;
        w_marks_full = (r_mark_count >= gsa_pkg::CNT_W'(gsa_pkg::SLOTS));
        w_gbit       = gsa_pkg::GROUPS'(1) << r_grp;
        if (!r_hv) begin
            w_chk = gsa_pkg::ST_NULL;
        end else if (!r_entry_q.in_use || (r_entry_q.rev != r_hrev)) begin
            w_chk = gsa_pkg::ST_STALE;
        end else begin
            w_chk = gsa_pkg::ST_OK;
        end
    end

    // Table writes of the clear sweep, the kill pass and the finishing step, and the result of the finishing step.
    always_comb begin
        w_status   = gsa_pkg::ST_OK;
        w_oidx     = '0;
        w_ovalid   = 1'b0;
        w_orev     = '0;
        w_removed  = '0;
        w_mark_inc = 1'b0;
        w_ent_we   = 1'b0;
        w_ent_wa   = r_cnt;
        w_ent_wd   = '0;
        w_alv_we   = 1'b0;
        w_alv_wa   = r_cnt[gsa_pkg::IDX_W-1:gsa_pkg::BSEL_W];
        w_alv_wd   = '0;
        if (i_ctl.clr_wr) begin
            w_ent_we = 1'b1;
            w_alv_we = 1'b1;
            w_alv_wa = r_cnt[gsa_pkg::WSEL_W-1:0];
        end else if (i_ctl.ps_wr) begin
            w_ent_we        = r_entry_q.mark;
            w_ent_wd        = r_entry_q;
            w_ent_wd.mark   = 1'b0;
            w_ent_wd.groups = '0;
            w_alv_we        = r_entry_q.mark;
            w_alv_wd        = r_alive_q & ~w_pass_bit;
        end else if (i_ctl.fin) begin
            case (r_cmd)
                gsa_pkg::CMD_SPAWN: begin
                    if (w_full) begin
                        w_status = gsa_pkg::ST_FULL;
                    end else begin
                        w_oidx          = r_slot;
                        w_ovalid        = 1'b1;
                        w_orev          = r_entry_q.rev + 1'b1;
                        w_ent_we        = 1'b1;
                        w_ent_wa        = r_slot;
                        w_ent_wd        = r_entry_q;
                        w_ent_wd.rev    = w_orev;
                        w_ent_wd.in_use = 1'b1;
                        w_alv_we        = 1'b1;
                        w_alv_wa        = r_wsel;
                        w_alv_wd        = r_alive_q | w_spawn_bit;
                    end
                end
                gsa_pkg::CMD_KILL: begin
                    if (w_marks_full) begin
                        w_status = gsa_pkg::ST_FULL;
                    end else if (w_chk != gsa_pkg::ST_OK) begin
                        w_status = w_chk;
                    end else begin
                        w_mark_inc    = !r_entry_q.mark;
                        w_ent_we      = 1'b1;
                        w_ent_wa      = r_idx;
                        w_ent_wd      = r_entry_q;
                        w_ent_wd.mark = 1'b1;
                        w_ent_wd.rev  = r_entry_q.rev + 1'b1;
                    end
                end
                gsa_pkg::CMD_PASS: begin
                    w_removed = r_mark_count;
                end
                default: begin
                    if (w_chk != gsa_pkg::ST_OK) begin
                        w_status = w_chk;
                    end else if ((r_entry_q.groups & w_gbit) != '0) begin
                        w_status = gsa_pkg::ST_MEMBER;
                    end else begin
                        w_ent_we        = 1'b1;
                        w_ent_wa        = r_idx;
                        w_ent_wd        = r_entry_q;
                        w_ent_wd.groups = r_entry_q.groups | w_gbit;
                    end
                end
            endcase
        end
    end

    // Read addresses.
    always_comb begin
        w_ent_re = i_ctl.sp_rd_entry | i_ctl.rd_entry | i_ctl.ps_rd;
        if (i_ctl.sp_rd_entry) begin
            w_ent_ra = {r_wsel, w_blow};
        end else if (i_ctl.rd_entry) begin
            w_ent_ra = r_idx;
        end else begin
            w_ent_ra = r_cnt;
        end
        w_alv_re = i_ctl.sp_rd_word | i_ctl.ps_rd;
        w_alv_ra = i_ctl.sp_rd_word ? w_wlow : r_cnt[gsa_pkg::IDX_W-1:gsa_pkg::BSEL_W];
    end

    // Slot table port.
    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            entry_mem[w_ent_wa] <= w_ent_wd;
        end
        if (w_ent_re) begin
            r_entry_q <= entry_mem[w_ent_ra];
        end
    end

    // Alive bitmap port.
    always_ff @(posedge i_clk) begin
        if (w_alv_we) begin
            alive_mem[w_alv_wa] <= w_alv_wd;
        end
        if (w_alv_re) begin
            r_alive_q <= alive_mem[w_alv_ra];
        end
    end

    // Request and search registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.req_ld) begin
            r_cmd  <= gsa_pkg::t_cmd'(i_s_tdata[1:0]);
            r_idx  <= i_s_tdata[11:2];
            r_hv   <= i_s_tdata[12];
            r_hrev <= i_s_tdata[28:13];
            r_grp  <= i_s_tdata[31:29];
        end
        if (i_ctl.sp_rd_word) begin
            r_wsel <= w_wlow;
        end
        if (i_ctl.sp_rd_entry) begin
            r_slot <= {r_wsel, w_blow};
        end
    end

    // Control counters and the full-word summary.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_sum        <= '0;
            r_mark_count <= '0;
        end else begin
            if (i_ctl.clr_wr || i_ctl.ps_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_ctl.ps_wr && r_entry_q.mark) begin
                r_sum[r_cnt[gsa_pkg::IDX_W-1:gsa_pkg::BSEL_W]] <= 1'b0;
            end else if (i_ctl.fin && (r_cmd == gsa_pkg::CMD_SPAWN) && !w_full) begin
                r_sum[r_wsel] <= &(r_alive_q | w_spawn_bit);
            end
            if (i_ctl.fin && (r_cmd == gsa_pkg::CMD_PASS)) begin
                r_mark_count <= '0;
            end else if (w_mark_inc) begin
                r_mark_count <= r_mark_count + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            r_out_data <= {7'd0, w_removed, w_orev, w_ovalid, w_oidx, w_status};
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out_data;
    assign o_sts.clr_last = (r_cnt == {gsa_pkg::IDX_W{1'b1}});
    assign o_sts.ps_last  = (r_cnt == {gsa_pkg::IDX_W{1'b1}});
    assign o_sts.full     = w_full;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

`ifndef ASSERT_OFF
    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark_count <= gsa_pkg::CNT_W'(gsa_pkg::SLOTS))
        else $error("mark count above table size");
    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.fin |=> r_out_valid)
        else $error("finished request produced no result");
    a_walk_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fin && (r_cmd == gsa_pkg::CMD_PASS)) |-> (r_cnt == '0))
        else $error("kill pass finished with walk counter off zero");
`endif

endmodule

// File: sv/generational_slot_allocator_unit.sv
// Generational slot allocator: a table of 1024 slots, each with a 16-bit
// revision, in-use flag, removal mark and eight group bits.
// Requests enter on the s-side stream (i_s_tvalid/o_s_tready/i_s_tdata),
// one result per request leaves on the m-side stream (o_m_tvalid/
// i_m_tready/o_m_tdata).
// One request is handled at a time. Spawn runs a summary search with bitmap
// word read, then a slot read, then a write back; kill and join run a slot
// read, then a check and write back. The kill pass walks every slot with a
// read and a write step each before it gives its result.
// After reset a clearing sweep writes one slot per cycle through all 1024
// slots; o_s_tready stays low until it ends.
// Results sit in an output register. A new request is accepted while the
// last result still waits; if the receiver stalls, the next request holds
// in its final step until the output register is free.
module generational_slot_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // cmd[1:0], slot_index[11:2], handle_valid[12], handle_revision[28:13],
    // group_index[31:29]
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[2:0], out_index[12:3], out_valid[13], out_revision[29:14],
    // removed_count[40:30], zero[47:41]
    output logic [47:0] o_m_tdata
);

    gsa_pkg::t_ctl w_ctl;
    gsa_pkg::t_sts w_sts;

    // Sequencer.
    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (gsa_pkg::t_cmd'(i_s_tdata[1:0])),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_ctl      (w_ctl)
    );

    // Table and result datapath.
    gsa_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// File: test/tb.sv
module tb;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic [2:0]    grp;
        logic [15:0]   rev;
        logic          hvalid;
        logic [9:0]    idx;
        gsa_pkg::t_cmd cmd;
    } t_req;

    // One result as it leaves the block.
    typedef struct packed {
        logic [6:0]       pad;
        logic [10:0]      removed;
        logic [15:0]      rev;
        logic             ovalid;
        logic [9:0]       idx;
        gsa_pkg::t_status status;
    } t_rsp;

    // One row of the directed table; check_row says the typed result is compared too.
    typedef struct {
        t_req req;
        bit   check_row;
        t_rsp rsp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;

    generational_slot_allocator_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    // Shadow copy of the slot table.
    bit          sh_alive [gsa_pkg::SLOTS];
    bit          sh_mark  [gsa_pkg::SLOTS];
    logic [7:0]  sh_groups[gsa_pkg::SLOTS];
    logic [15:0] sh_rev   [gsa_pkg::SLOTS];
    bit          sh_in_use[gsa_pkg::SLOTS];
    int          sh_alive_cnt;
    int          sh_mark_cnt;

    t_rsp        pending_rsp[$];
    t_rsp        typed_rsp[$];
    bit          typed_valid[$];
    int          errors;
    int          n_results;
    int          n_requests;
    int          cycles;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          hold_rcv;
    t_row        rows[$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Global watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
    endtask

    // Handle check: ok, null handle or stale handle.
    function automatic gsa_pkg::t_status handle_status(t_req r);
        if (!r.hvalid) return gsa_pkg::ST_NULL;
        if (!sh_in_use[r.idx] || sh_rev[r.idx] != r.rev) return gsa_pkg::ST_STALE;
        return gsa_pkg::ST_OK;
    endfunction

    // Apply one request to the shadow table and return the result it gives.
    function automatic t_rsp allocate_step(t_req r);
        t_rsp             o;
        gsa_pkg::t_status chk;
        int               k;
        o = '0;
        case (r.cmd)
            gsa_pkg::CMD_SPAWN: begin
                if (sh_alive_cnt >= gsa_pkg::SLOTS) o.status = gsa_pkg::ST_FULL;
                else begin
                    k = 0;
                    while (sh_alive[k]) k++;
                    sh_alive[k]  = 1;
                    sh_alive_cnt++;
                    sh_rev[k]    = sh_rev[k] + 16'd1;
                    sh_in_use[k] = 1;
                    o.idx    = 10'(k);
                    o.ovalid = 1'b1;
                    o.rev    = sh_rev[k];
                end
            end
            gsa_pkg::CMD_KILL: begin
                if (sh_mark_cnt >= gsa_pkg::SLOTS) o.status = gsa_pkg::ST_FULL;
                else begin
                    chk = handle_status(r);
                    o.status = chk;
                    if (chk == gsa_pkg::ST_OK) begin
                        if (!sh_mark[r.idx]) begin
                            sh_mark[r.idx] = 1;
                            sh_mark_cnt++;
                        end
                        sh_rev[r.idx] = sh_rev[r.idx] + 16'd1;
                    end
                end
            end
            gsa_pkg::CMD_PASS: begin
                for (int i = 0; i < gsa_pkg::SLOTS; i++) begin
                    if (sh_mark[i]) begin
                        if (sh_alive[i]) begin
                            sh_alive[i] = 0;
                            sh_alive_cnt--;
                        end
                        sh_groups[i] = '0;
                        sh_mark[i]   = 0;
                        o.removed++;
                    end
                end
                sh_mark_cnt = 0;
            end
            default: begin
                chk = handle_status(r);
                o.status = chk;
                if (chk == gsa_pkg::ST_OK) begin
                    if (sh_groups[r.idx][r.grp]) o.status = gsa_pkg::ST_MEMBER;
                    else sh_groups[r.idx][r.grp] = 1'b1;
                end
            end
        endcase
        return o;
    endfunction

    // Send one request; the expectation is queued at acceptance.
    task automatic send_request(input t_req r, input bit typed, input t_rsp want);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= r;
        do @(posedge i_clk); while (!o_s_tready);
        pending_rsp.push_back(allocate_step(r));
        typed_valid.push_back(typed);
        typed_rsp.push_back(want);
        n_requests++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= !hold_rcv && ($urandom_range(99) >= rcv_idle_pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_rsp got, want, typed;
        bit   tv;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            n_results++;
            if (pending_rsp.size() == 0) report("unexpected result", 1, 0);
            else begin
                want  = pending_rsp.pop_front();
                typed = typed_rsp.pop_front();
                tv    = typed_valid.pop_front();
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.idx != want.idx) report("out_index", got.idx, want.idx);
                if (got.ovalid != want.ovalid) report("out_valid", got.ovalid, want.ovalid);
                if (got.rev != want.rev) report("out_revision", got.rev, want.rev);
                if (got.removed != want.removed)
                    report("removed_count", got.removed, want.removed);
                if (got.pad != '0) report("padding", got.pad, 0);
                if (tv && got != typed) report("directed row", 1, 0);
            end
        end
    end

    function automatic t_req mk(gsa_pkg::t_cmd c, int idx, bit v, int rev, int grp);
        t_req r;
        r.cmd = c; r.idx = 10'(idx); r.hvalid = v; r.rev = 16'(rev); r.grp = 3'(grp);
        return r;
    endfunction

    function automatic t_rsp rs(gsa_pkg::t_status s, int idx, bit v, int rev, int rem);
        t_rsp o;
        o = '0;
        o.status = s; o.idx = 10'(idx); o.ovalid = v; o.rev = 16'(rev);
        o.removed = 11'(rem);
        return o;
    endfunction

    // Random handle, mostly taken from the shadow so that it is live.
    function automatic t_req rand_handle(gsa_pkg::t_cmd c);
        t_req r;
        int   k;
        k = $urandom_range(15);
        r = mk(c, $urandom_range(1023), 1'($urandom_range(1)), $urandom, $urandom_range(7));
        if (k < 12) begin
            r.idx    = 10'($urandom_range(k < 9 ? 63 : 1023));
            r.hvalid = 1'b1;
            r.rev    = (k == 11) ? sh_rev[r.idx] + 16'd1 : sh_rev[r.idx];
        end
        return r;
    endfunction

    task automatic random_phase(input int count);
        t_req r;
        int   k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            if (k < 35) r = mk(gsa_pkg::CMD_SPAWN, $urandom, 1'($urandom), $urandom, $urandom);
            else if (k < 65) r = rand_handle(gsa_pkg::CMD_KILL);
            else if (k < 70) r = mk(gsa_pkg::CMD_PASS, $urandom, 1'($urandom), $urandom,
                                    $urandom);
            else r = rand_handle(gsa_pkg::CMD_JOIN);
            send_request(r, 0, '0);
        end
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        cycles = 0; errors = 0; n_results = 0; n_requests = 0;
        hold_rcv = 0; snd_idle_pct = 0; rcv_idle_pct = 0;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0;
        foreach (sh_alive[i]) begin
            sh_alive[i] = 0; sh_mark[i] = 0; sh_groups[i] = '0;
            sh_rev[i] = '0; sh_in_use[i] = 0;
        end
        sh_alive_cnt = 0; sh_mark_cnt = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: fresh spawns, null and stale handles, groups, kills, pass.
        rows.push_back('{mk(gsa_pkg::CMD_KILL, 0, 0, 0, 0), 1,
                         rs(gsa_pkg::ST_NULL, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_JOIN, 1023, 1, 16'hFFFF, 7), 1,
                         rs(gsa_pkg::ST_STALE, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_SPAWN, 0, 0, 0, 0), 1,
                         rs(gsa_pkg::ST_OK, 0, 1, 1, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_SPAWN, 1023, 1, 16'hFFFF, 7), 1,
                         rs(gsa_pkg::ST_OK, 1, 1, 1, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_KILL, 0, 1, 0, 0), 1,
                         rs(gsa_pkg::ST_STALE, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_JOIN, 0, 1, 1, 7), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_JOIN, 0, 1, 1, 7), 1,
                         rs(gsa_pkg::ST_MEMBER, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_JOIN, 0, 1, 1, 0), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_JOIN, 0, 0, 1, 0), 1,
                         rs(gsa_pkg::ST_NULL, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_KILL, 1, 1, 1, 3), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 0)});
        // Kill again with the new revision: mark stays, revision moves on.
        rows.push_back('{mk(gsa_pkg::CMD_KILL, 1, 1, 2, 3), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_JOIN, 1, 1, 3, 5), 0, '0});
        rows.push_back('{mk(gsa_pkg::CMD_PASS, 1023, 1, 16'hFFFF, 7), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 1)});
        rows.push_back('{mk(gsa_pkg::CMD_PASS, 0, 0, 0, 0), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 0)});
        // Released slot 1 is still in use, so a kill of a dead slot is legal.
        rows.push_back('{mk(gsa_pkg::CMD_KILL, 1, 1, 3, 0), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_SPAWN, 0, 0, 0, 0), 1,
                         rs(gsa_pkg::ST_OK, 1, 1, 5, 0)});
        rows.push_back('{mk(gsa_pkg::CMD_PASS, 0, 0, 0, 0), 1,
                         rs(gsa_pkg::ST_OK, 0, 0, 0, 1)});
        rows.push_back('{mk(gsa_pkg::CMD_JOIN, 1, 1, 5, 3), 0, '0});
        foreach (rows[i]) send_request(rows[i].req, rows[i].check_row, rows[i].rsp);
        drain();

        // A burst of spawns against one long receiver hold, so the input stalls.
        fork
            begin
                hold_rcv = 1;
                repeat (300) @(posedge i_clk);
                hold_rcv = 0;
            end
            for (int n = 0; n < 200; n++) send_request(mk(gsa_pkg::CMD_SPAWN, $urandom,
                                                          1'($urandom), $urandom, $urandom),
                                                       0, '0);
        join
        // Kill the sixteen top indexes and join at every one-hot index.
        for (int b = 0; b < 16; b++) begin
            send_request(mk(gsa_pkg::CMD_KILL, 1023 - b, 1, sh_rev[1023 - b], $urandom),
                         0, '0);
            send_request(mk(gsa_pkg::CMD_JOIN, 1 << (b % 10), 1, $urandom, b % 8), 0, '0);
        end
        send_request(mk(gsa_pkg::CMD_PASS, 0, 0, 0, 0), 0, '0);
        drain();

        snd_idle_pct = 15; rcv_idle_pct = 51;
        random_phase(166);
        snd_idle_pct = 51; rcv_idle_pct = 15;
        random_phase(166);
        snd_idle_pct = 0; rcv_idle_pct = 0;
        random_phase(166);
        drain();

        $display("covered %0d requests and %0d results: spawn, kill, join, kill pass,",
                 n_requests, n_results);
        $display("null/stale handles, repeat membership, receiver back-pressure");
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
